// ===== rtl/csi_pkg.sv =====
// Package with the shared types, constants and codes of the cardinal spline interpolator.
`timescale 1ns / 1ps
package csi_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int VALUE_WIDTH = 32;
   localparam int TENSION_W   = 17;

   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_Q_W   = 21;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_POINT_COUNT = 1'b0,
      CSR_TENSION     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_CLAMP  = 2'd1,
      ST_FEW    = 2'd2,
      ST_REPEAT = 2'd3
   } status_type;

   typedef struct packed {
      req_kind_type                   req_type;
      logic [5:0]                     point_index;
      logic signed [VALUE_WIDTH-1:0]  point_x;
      logic signed [VALUE_WIDTH-1:0]  point_y;
      logic signed [VALUE_WIDTH-1:0]  query_x;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  result_x;
      logic signed [VALUE_WIDTH-1:0]  result_y;
      status_type                     status;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_SRCH,
      OP_EMPTY,
      OP_CLAMP,
      OP_LATCH,
      OP_DIV_T,
      OP_T_SET,
      OP_M_TT,
      OP_T2_SET,
      OP_M_T2T,
      OP_T3_SET,
      OP_M_DYC,
      OP_DYC_SET,
      OP_DIV_R,
      OP_R_SET,
      OP_M_M,
      OP_M_SET,
      OP_M_ACC,
      OP_ACC_ADD,
      OP_FIN,
      OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [IDX_W-1:0]  addr;
      logic [1:0]        sel;
      logic              first;
   } dp_cmd_type;

   typedef struct packed {
      logic              hit;
      logic              below;
      logic              div_busy;
      logic              out_free;
      logic [CNT_W-1:0]  n;
   } dp_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SRCH,
      S_CLAMP_RD,
      S_CLAMP_LD,
      S_LOAD,
      S_DT_GO,
      S_DT_WAIT,
      S_T_SET,
      S_M_TT,
      S_T2,
      S_M_T2T,
      S_T3,
      S_M_DYC,
      S_DYC,
      S_DR_GO,
      S_DR_WAIT,
      S_R_SET,
      S_M_M,
      S_M_SET,
      S_M_ACC,
      S_ACC,
      S_FIN,
      S_DONE
   } ctl_state_type;

endpackage

// ===== rtl/cardinal_spline_interpolator.sv =====
// Top level of the cardinal spline interpolator: controller, datapath and the port handshakes.
`timescale 1ns / 1ps
// A load transfer writes one control point and gives no result. A query transfer gives
// one result: with an empty or single-point table no search is made, otherwise the segment
// search reads one point per cycle from the point memory, and an interior segment then
// adds three divisions, each with a 21-bit quotient, on the one shared serial divider.
// The block takes one query at a time; the result register lets the next transfer be
// accepted while a finished result still waits. Configuration writes are always accepted.
module cardinal_spline_interpolator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csi_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csi_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csi_pkg::csr_index_type    csr_index,
   input  logic [16:0]               csr_data
);
   import csi_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_accept;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;

   csi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_payload.req_type),
      .cmd       (cmd),
      .sts       (sts)
   );

   csi_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/csi_div.sv =====
// Restoring unsigned divider that yields one quotient bit per cycle with an overflow flag.
`timescale 1ns / 1ps
module csi_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [csi_pkg::DIV_NUM_W-1:0]  num,
   input  logic [csi_pkg::DIV_DEN_W-1:0]  den,
   output logic                           busy,
   output logic [csi_pkg::DIV_Q_W-1:0]    quo,
   output logic                           ovf
);
   import csi_pkg::*;

   localparam int DSH_W = DIV_DEN_W + DIV_Q_W - 1;
   localparam int CW    = $clog2(DIV_Q_W + 1);

   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0]     dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 ge;
   logic [DSH_W-1:0]     diff;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      ge     = DSH_W'(rem_ff) >= dsh_ff;
      diff   = DSH_W'(rem_ff) - dsh_ff;
      if (start) begin
         rem_in = num;
         dsh_in = {den, {(DIV_Q_W-1){1'b0}}};
         quo_in = '0;
         cnt_in = CW'(DIV_Q_W);
         ovf_in = (DSH_W+1)'(num) >= {den, {DIV_Q_W{1'b0}}};
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_in = diff[DIV_NUM_W-1:0];
         end
         quo_in = {quo_ff[DIV_Q_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = cnt_ff != '0;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== rtl/csi_datapath.sv =====
// Datapath with the point memories, configuration registers, multiplier, divider and result stage.
`timescale 1ns / 1ps
module csi_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  csi_pkg::dp_cmd_type       cmd,
   output csi_pkg::dp_sts_type       sts,
   input  logic                      req_accept,
   input  csi_pkg::req_payload_type  req_payload,
   input  logic                      csr_valid,
   input  csi_pkg::csr_index_type    csr_index,
   input  logic [16:0]               csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csi_pkg::rsp_payload_type  rsp_payload
);
   import csi_pkg::*;

   localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic signed [VALUE_WIDTH-1:0] x_mem [MAX_POINTS];
   logic signed [VALUE_WIDTH-1:0] y_mem [MAX_POINTS];

   logic [CNT_W-1:0]     count_ff;
   logic [TENSION_W-1:0] tension_ff;
   logic [CNT_W-1:0]     n_w;

   logic signed [VALUE_WIDTH-1:0] rd_x_ff, rd_y_ff, q_ff;
   logic signed [VALUE_WIDTH-1:0] xk_ff, xk1_ff, xm_ff, xp_ff;
   logic signed [VALUE_WIDTH-1:0] yk_ff, yk1_ff, ym_ff, yp_ff;
   logic                          ge_prev_ff, below_ff, lt;

   logic signed [32:0] dx, u, dy_s, dxx_s;
   logic        [32:0] dxx_mag;

   logic                   div_start, div_busy, div_ovf;
   logic [DIV_NUM_W-1:0]   div_num;
   logic [DIV_DEN_W-1:0]   div_den;
   logic [DIV_Q_W-1:0]     div_quo, qsat;

   logic [15:0]            t_ff, t2_ff, t3_ff;
   logic signed [19:0]     h00, h10, h01, h11, st, st2, st3;
   logic [TENSION_W-1:0]   clamp_c, omc;
   logic signed [33:0]     dyc_ff;
   logic signed [21:0]     r_ff;
   logic                   z_ff, bad_ff;
   logic signed [39:0]     m0_ff, m1_ff, mval;

   logic signed [40:0]     mul_a;
   logic signed [21:0]     mul_b;
   logic                   mul_en;
   logic signed [62:0]     prod_ff;
   logic signed [63:0]     acc_ff;
   logic signed [47:0]     yfl;

   logic signed [VALUE_WIDTH-1:0] yv_ff;
   status_type                    stat_ff;
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_ff;

   assign n_w = (count_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         tension_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POINT_COUNT: count_ff   <= csr_data[CNT_W-1:0];
            CSR_TENSION:     tension_ff <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_payload.req_type == REQ_LOAD) begin
         x_mem[req_payload.point_index[IDX_W-1:0]] <= req_payload.point_x;
         y_mem[req_payload.point_index[IDX_W-1:0]] <= req_payload.point_y;
      end
      rd_x_ff <= x_mem[cmd.addr];
      rd_y_ff <= y_mem[cmd.addr];
   end

   assign lt = q_ff < rd_x_ff;

   assign dx      = 33'(xk1_ff) - 33'(xk_ff);
   assign u       = 33'(q_ff) - 33'(xk_ff);
   assign dy_s    = cmd.sel[0] ? (33'(yp_ff) - 33'(yk_ff))  : (33'(yk1_ff) - 33'(ym_ff));
   assign dxx_s   = cmd.sel[0] ? (33'(xp_ff) - 33'(xk_ff))  : (33'(xk1_ff) - 33'(xm_ff));
   assign dxx_mag = dxx_s[32] ? 33'(-dxx_s) : 33'(dxx_s);

   always_comb begin
      div_start = 1'b0;
      div_num   = {1'b0, u[31:0], 16'd0};
      div_den   = {1'b0, dx[31:0]};
      unique case (cmd.op)
         OP_DIV_T: div_start = 1'b1;
         OP_DIV_R: begin
            div_start = 1'b1;
            div_num   = {1'b0, dx[31:0], 16'd0};
            div_den   = dxx_mag;
         end
         default: div_start = 1'b0;
      endcase
   end

   csi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   assign qsat = (div_ovf || div_quo > (DIV_Q_W'(1) << 20)) ? (DIV_Q_W'(1) << 20) : div_quo;

   assign st  = 20'(t_ff);
   assign st2 = 20'(t2_ff);
   assign st3 = 20'(t3_ff);
   assign h00 = 20'(2 * st3 - 3 * st2 + 20'sd65536);
   assign h10 = 20'(st3 - 2 * st2 + st);
   assign h01 = 20'(3 * st2 - 2 * st3);
   assign h11 = 20'(st3 - st2);

   assign clamp_c = (tension_ff > TENSION_W'(65536)) ? TENSION_W'(65536) : tension_ff;
   assign omc     = TENSION_W'(65536) - clamp_c;

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (cmd.op)
         OP_M_TT: begin
            mul_a = 41'(t_ff);
            mul_b = 22'(t_ff);
         end
         OP_M_T2T: begin
            mul_a = 41'(t2_ff);
            mul_b = 22'(t_ff);
         end
         OP_M_DYC: begin
            mul_a = 41'(dy_s);
            mul_b = 22'(omc);
         end
         OP_M_M: begin
            mul_a = 41'(dyc_ff);
            mul_b = r_ff;
         end
         OP_M_ACC: begin
            unique case (cmd.sel)
               2'd0: begin mul_a = 41'(yk_ff);  mul_b = 22'(h00); end
               2'd1: begin mul_a = 41'(m0_ff);  mul_b = 22'(h10); end
               2'd2: begin mul_a = 41'(yk1_ff); mul_b = 22'(h01); end
               2'd3: begin mul_a = 41'(m1_ff);  mul_b = 22'(h11); end
            endcase
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign mval = z_ff ? 40'sd0 : prod_ff[55:16];
   assign yfl  = acc_ff[63:16];

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (req_accept && req_payload.req_type == REQ_QUERY) begin
         q_ff <= req_payload.query_x;
      end
      unique case (cmd.op)
         OP_SRCH: begin
            ge_prev_ff <= !lt;
            if (cmd.first) begin
               below_ff <= lt;
            end
         end
         OP_EMPTY: begin
            yv_ff   <= '0;
            stat_ff <= ST_FEW;
         end
         OP_CLAMP: begin
            yv_ff   <= rd_y_ff;
            stat_ff <= cmd.sel[0] ? ST_FEW : ST_CLAMP;
         end
         OP_LATCH: begin
            unique case (cmd.sel)
               2'd0: begin xk_ff  <= rd_x_ff; yk_ff  <= rd_y_ff; end
               2'd1: begin xk1_ff <= rd_x_ff; yk1_ff <= rd_y_ff; end
               2'd2: begin xm_ff  <= rd_x_ff; ym_ff  <= rd_y_ff; end
               2'd3: begin xp_ff  <= rd_x_ff; yp_ff  <= rd_y_ff; end
            endcase
         end
         OP_T_SET:   t_ff  <= div_quo[15:0];
         OP_T2_SET:  t2_ff <= prod_ff[31:16];
         OP_T3_SET: begin
            t3_ff  <= prod_ff[31:16];
            acc_ff <= '0;
         end
         OP_DYC_SET: dyc_ff <= prod_ff[49:16];
         OP_R_SET: begin
            z_ff <= dxx_s == 33'sd0;
            r_ff <= dxx_s[32] ? 22'(-$signed({1'b0, qsat})) : 22'($signed({1'b0, qsat}));
         end
         OP_M_SET: begin
            if (cmd.sel[0]) begin
               m1_ff <= mval;
            end else begin
               m0_ff <= mval;
            end
         end
         OP_ACC_ADD: acc_ff <= acc_ff + 64'(prod_ff);
         OP_FIN: begin
            if (yfl > 48'(VMAX)) begin
               yv_ff <= VMAX;
            end else if (yfl < 48'(VMIN)) begin
               yv_ff <= VMIN;
            end else begin
               yv_ff <= yfl[VALUE_WIDTH-1:0];
            end
            stat_ff <= bad_ff ? ST_REPEAT : ST_OK;
         end
         OP_PUSH: rsp_ff <= '{result_x: q_ff, result_y: yv_ff, status: stat_ff};
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept && req_payload.req_type == REQ_QUERY) begin
            bad_ff <= 1'b0;
         end else if (cmd.op == OP_M_SET && z_ff) begin
            bad_ff <= 1'b1;
         end
         if (cmd.op == OP_PUSH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.hit      = (cmd.op == OP_SRCH) && !cmd.first && ge_prev_ff && lt;
   assign sts.below    = below_ff;
   assign sts.div_busy = div_busy;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.n        = n_w;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/csi_ctrl.sv =====
// Controller state machine that sequences the segment search, the divisions and the blend.
`timescale 1ns / 1ps
module csi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csi_pkg::req_kind_type  req_kind,
   output csi_pkg::dp_cmd_type    cmd,
   input  csi_pkg::dp_sts_type    sts
);
   import csi_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in, idx_ff, idx_in, nm1, kp2w;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [2:0]        sub_ff, sub_in;
   logic              cmpv_ff, cmpv_in, few_ff, few_in;

   assign nm1  = n_ff - CNT_W'(1);
   assign kp2w = CNT_W'(k_ff) + CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         idx_ff   <= '0;
         k_ff     <= '0;
         sub_ff   <= '0;
         cmpv_ff  <= 1'b0;
         few_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
         sub_ff   <= sub_in;
         cmpv_ff  <= cmpv_in;
         few_ff   <= few_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      sub_in    = sub_ff;
      cmpv_in   = cmpv_ff;
      few_in    = few_ff;
      req_ready = 1'b0;
      cmd       = '{op: OP_NONE, addr: '0, sel: sub_ff[1:0], first: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind == REQ_QUERY) begin
               n_in    = sts.n;
               idx_in  = '0;
               cmpv_in = 1'b0;
               few_in  = 1'b0;
               if (sts.n == '0) begin
                  cmd.op   = OP_EMPTY;
                  state_in = S_DONE;
               end else if (sts.n == CNT_W'(1)) begin
                  few_in   = 1'b1;
                  state_in = S_CLAMP_RD;
               end else begin
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            cmd.addr = idx_ff[IDX_W-1:0];
            if (idx_ff != n_ff) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            cmpv_in = idx_ff != n_ff;
            if (cmpv_ff) begin
               cmd.op    = OP_SRCH;
               cmd.first = idx_ff == CNT_W'(1);
               if (sts.hit) begin
                  k_in     = IDX_W'(idx_ff - CNT_W'(2));
                  sub_in   = '0;
                  state_in = S_LOAD;
               end else if (idx_ff == n_ff) begin
                  state_in = S_CLAMP_RD;
               end
            end
         end
         S_CLAMP_RD: begin
            cmd.addr = (few_ff || sts.below) ? '0 : nm1[IDX_W-1:0];
            state_in = S_CLAMP_LD;
         end
         S_CLAMP_LD: begin
            cmd.op   = OP_CLAMP;
            cmd.sel  = {1'b0, few_ff};
            state_in = S_DONE;
         end
         S_LOAD: begin
            unique case (sub_ff)
               3'd0:    cmd.addr = k_ff;
               3'd1:    cmd.addr = k_ff + IDX_W'(1);
               3'd2:    cmd.addr = (k_ff == '0) ? k_ff : k_ff - IDX_W'(1);
               3'd3:    cmd.addr = (kp2w <= nm1) ? kp2w[IDX_W-1:0] : nm1[IDX_W-1:0];
               default: cmd.addr = k_ff;
            endcase
            if (sub_ff != '0) begin
               cmd.op  = OP_LATCH;
               cmd.sel = 2'(sub_ff - 3'd1);
            end
            if (sub_ff == 3'd4) begin
               state_in = S_DT_GO;
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         S_DT_GO: begin
            cmd.op   = OP_DIV_T;
            state_in = S_DT_WAIT;
         end
         S_DT_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_T_SET;
            end
         end
         S_T_SET: begin
            cmd.op   = OP_T_SET;
            state_in = S_M_TT;
         end
         S_M_TT: begin
            cmd.op   = OP_M_TT;
            state_in = S_T2;
         end
         S_T2: begin
            cmd.op   = OP_T2_SET;
            state_in = S_M_T2T;
         end
         S_M_T2T: begin
            cmd.op   = OP_M_T2T;
            state_in = S_T3;
         end
         S_T3: begin
            cmd.op   = OP_T3_SET;
            sub_in   = '0;
            state_in = S_M_DYC;
         end
         S_M_DYC: begin
            cmd.op   = OP_M_DYC;
            state_in = S_DYC;
         end
         S_DYC: begin
            cmd.op   = OP_DYC_SET;
            state_in = S_DR_GO;
         end
         S_DR_GO: begin
            cmd.op   = OP_DIV_R;
            state_in = S_DR_WAIT;
         end
         S_DR_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_R_SET;
            end
         end
         S_R_SET: begin
            cmd.op   = OP_R_SET;
            state_in = S_M_M;
         end
         S_M_M: begin
            cmd.op   = OP_M_M;
            state_in = S_M_SET;
         end
         S_M_SET: begin
            cmd.op = OP_M_SET;
            if (sub_ff[0]) begin
               sub_in   = '0;
               state_in = S_M_ACC;
            end else begin
               sub_in   = 3'd1;
               state_in = S_M_DYC;
            end
         end
         S_M_ACC: begin
            cmd.op   = OP_M_ACC;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC_ADD;
            if (sub_ff == 3'd3) begin
               state_in = S_FIN;
            end else begin
               sub_in   = sub_ff + 3'd1;
               state_in = S_M_ACC;
            end
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.op   = OP_PUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_div_only_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.div_busy |-> (state_ff == S_DT_WAIT || state_ff == S_DR_WAIT))
      else $error("divider busy outside a wait state");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH) |-> sts.out_free)
      else $error("result pushed into an occupied output stage");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (idx_ff <= n_ff))
      else $error("search index ran past the point count");

   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == REQ_QUERY) |=> (state_ff != S_IDLE))
      else $error("query transfer did not start work");
`endif

endmodule
